// File: rtl/are_pkg.sv
// are_pkg: shared types and constants for the axis reduction engine.
// No dependencies; imported by are_front, are_back and axis_reduction_engine.
package are_pkg;

  localparam int CFG_DW      = 17;   // widest configuration register
  localparam int CFG_IW      = 2;    // register index width
  localparam int MODE_W      = 3;
  localparam int AXIS_REG_W  = 13;
  localparam int INNER_REG_W = 11;
  localparam int OUTER_REG_W = 17;
  localparam int RES_W       = 28;
  localparam int MAX_SLABS   = 65536;

  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODE  = 2'd0;
  localparam cfg_idx_t REG_AXIS  = 2'd1;
  localparam cfg_idx_t REG_INNER = 2'd2;
  localparam cfg_idx_t REG_OUTER = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM    = 3'd0,
    MODE_MEAN   = 3'd1,
    MODE_MIN    = 3'd2,
    MODE_MAX    = 3'd3,
    MODE_ARGMIN = 3'd4,
    MODE_ARGMAX = 3'd5
  } mode_t;

  // Per-word classification made by the front end.
  typedef struct packed {
    logic first;        // row 0: initializes the column
    logic emit;         // last row: produces a result
    logic last_tensor;  // final result of the tensor
  } ctl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPD,
    BK_DIV
  } bk_state_t;

endpackage

// File: rtl/are_fifo.sv
// are_fifo: small register-based queue used between front/back and at the output.
// Depends on nothing.
module are_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             wr_ok, rd_ok;

  assign full  = (cnt_r == NW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_ok = push & ~full;
  assign rd_ok = pop & ~empty;
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_ok ? ((wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1)) : wp_r;
    rp_nxt  = rd_ok ? ((rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r;
    case ({wr_ok, rd_ok})
      2'b10:   cnt_nxt = cnt_r + NW'(1);
      2'b01:   cnt_nxt = cnt_r - NW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// File: rtl/are_ram.sv
// are_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module are_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// File: rtl/are_front.sv
// are_front: configuration registers, column/row/slab position counters and
// word classification. Depends on are_pkg.
module are_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_AXIS    = 4096,
  parameter int ELEM_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  are_pkg::cfg_idx_t                  cfg_index,
  input  logic [are_pkg::CFG_DW-1:0]         cfg_data,
  input  logic                               in_push,
  input  logic signed [ELEM_WIDTH-1:0]       in_element,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [3 + $clog2(MAX_AXIS + 1) + ((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)
                + ELEM_WIDTH - 1:0]          q_data,
  output are_pkg::mode_t                     mode,
  output logic [$clog2(MAX_AXIS + 1)-1:0]    axis
);
  import are_pkg::*;

  localparam int LW  = $clog2(MAX_AXIS + 1);
  localparam int CLW = $clog2(MAX_COLUMNS + 1);
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [MODE_W-1:0]      mode_reg_r;
  logic [AXIS_REG_W-1:0]  axis_reg_r;
  logic [INNER_REG_W-1:0] inner_reg_r;
  logic [OUTER_REG_W-1:0] outer_reg_r;

  logic [CLW-1:0]         col_r, col_nxt;
  logic [LW-1:0]          row_r, row_nxt;
  logic [OUTER_REG_W-1:0] slab_r, slab_nxt;

  logic [LW-1:0]          axis_c;
  logic [CLW-1:0]         inner_c;
  logic [OUTER_REG_W-1:0] outer_c;
  logic                   col_end, row_end, slab_end;
  ctl_t                   ctl;

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (axis_reg_r == '0) begin
      axis_c = LW'(1);
    end else if (32'(axis_reg_r) > 32'(MAX_AXIS)) begin
      axis_c = LW'(MAX_AXIS);
    end else begin
      axis_c = LW'(axis_reg_r);
    end
    if (inner_reg_r == '0) begin
      inner_c = CLW'(1);
    end else if (32'(inner_reg_r) > 32'(MAX_COLUMNS)) begin
      inner_c = CLW'(MAX_COLUMNS);
    end else begin
      inner_c = CLW'(inner_reg_r);
    end
    if (outer_reg_r == '0) begin
      outer_c = OUTER_REG_W'(1);
    end else if (outer_reg_r > OUTER_REG_W'(MAX_SLABS)) begin
      outer_c = OUTER_REG_W'(MAX_SLABS);
    end else begin
      outer_c = outer_reg_r;
    end
  end

  always_comb begin
    case (mode_reg_r)
      MODE_MEAN:   mode = MODE_MEAN;
      MODE_MIN:    mode = MODE_MIN;
      MODE_MAX:    mode = MODE_MAX;
      MODE_ARGMIN: mode = MODE_ARGMIN;
      MODE_ARGMAX: mode = MODE_ARGMAX;
      default:     mode = MODE_SUM;
    endcase
  end

  assign axis = axis_c;

  always_comb begin
    col_end  = (col_r + CLW'(1)) >= inner_c;
    row_end  = (row_r + LW'(1)) >= axis_c;
    slab_end = (slab_r + OUTER_REG_W'(1)) >= outer_c;

    ctl.first       = (row_r == '0);
    ctl.emit        = row_end;
    ctl.last_tensor = row_end & col_end & slab_end;

    col_nxt  = col_end ? '0 : col_r + CLW'(1);
    row_nxt  = col_end ? (row_end ? '0 : row_r + LW'(1)) : row_r;
    slab_nxt = (col_end & row_end) ? (slab_end ? '0 : slab_r + OUTER_REG_W'(1)) : slab_r;
  end

  assign q_push = in_push & ~q_full;
  assign q_data = {ctl, row_r, col_r[CIW-1:0], in_element};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_reg_r  <= '0;
      axis_reg_r  <= AXIS_REG_W'(1);
      inner_reg_r <= INNER_REG_W'(1);
      outer_reg_r <= OUTER_REG_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      slab_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_reg_r  <= cfg_data[MODE_W-1:0];
        REG_AXIS:  axis_reg_r  <= cfg_data[AXIS_REG_W-1:0];
        REG_INNER: inner_reg_r <= cfg_data[INNER_REG_W-1:0];
        REG_OUTER: outer_reg_r <= cfg_data[OUTER_REG_W-1:0];
        default:   mode_reg_r  <= mode_reg_r;
      endcase
      // any write restarts the tensor
      col_r  <= '0;
      row_r  <= '0;
      slab_r <= '0;
    end else if (q_push) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slab_r <= slab_nxt;
    end
  end

endmodule

// File: rtl/are_back.sv
// are_back: per-column read-modify-write on the accumulator RAMs, mean divider
// and result saturation. Depends on are_pkg and are_ram.
module are_back #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_AXIS    = 4096,
  parameter int ELEM_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  logic [3 + $clog2(MAX_AXIS + 1) + ((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)
                + ELEM_WIDTH - 1:0]          q_data,
  output logic                               q_pop,
  input  are_pkg::mode_t                     mode,
  input  logic [$clog2(MAX_AXIS + 1)-1:0]    axis,
  input  logic                               out_full,
  output logic                               out_push,
  output logic [are_pkg::RES_W:0]            out_data
);
  import are_pkg::*;

  localparam int EW  = ELEM_WIDTH;
  localparam int LW  = $clog2(MAX_AXIS + 1);
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CTW = $bits(ctl_t);
  localparam int IW  = CTW + LW + CIW + EW;
  localparam int AW  = EW + LW;            // accumulator width
  localparam int DW  = AW + 8;             // scaled dividend width
  localparam int SW  = DW + 1;             // signed quotient width
  localparam int XW  = (SW > RES_W) ? SW : RES_W;
  localparam int CNW = $clog2(DW + 1);
  localparam logic signed [XW-1:0] SMAX = XW'((64'sd1 <<< (RES_W - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

  bk_state_t state_r, state_nxt;

  ctl_t                 ctl_r;
  logic [LW-1:0]        row_r;
  logic [CIW-1:0]       col_r;
  logic signed [EW-1:0] elem_r;

  logic                 neg_r;
  logic [DW-1:0]        q_r, q_step;
  logic [LW-1:0]        rem_r, rem_step;
  logic [LW-1:0]        div_r;
  logic [CNW-1:0]       cnt_r;
  logic [LW:0]          rem_sh;

  logic signed [AW-1:0] acc_rd, acc_new, xa;
  logic signed [EW-1:0] best_rd, best_new;
  logic [AW-1:0]        mag;
  logic signed [SW-1:0] q_s, mean_val;
  logic                 is_arg, load;

  function automatic logic [RES_W-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    c = v;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end
    return c[RES_W-1:0];
  endfunction

  are_ram #(.WIDTH(AW), .DEPTH(MAX_COLUMNS)) u_acc_ram (
    .clk   (clk),
    .we    (state_r == BK_UPD),
    .waddr (col_r),
    .wdata (acc_new),
    .raddr (q_data[EW +: CIW]),
    .rdata (acc_rd)
  );

  are_ram #(.WIDTH(EW), .DEPTH(MAX_COLUMNS)) u_best_ram (
    .clk   (clk),
    .we    (state_r == BK_UPD),
    .waddr (col_r),
    .wdata (best_new),
    .raddr (q_data[EW +: CIW]),
    .rdata (best_rd)
  );

  // column update
  always_comb begin
    is_arg   = (mode == MODE_ARGMIN) || (mode == MODE_ARGMAX);
    xa       = AW'(elem_r);
    acc_new  = acc_rd;
    best_new = best_rd;
    if (ctl_r.first) begin
      best_new = elem_r;
      acc_new  = is_arg ? '0 : xa;
    end else begin
      case (mode)
        MODE_MIN: begin
          if (xa < acc_rd) acc_new = xa;
        end
        MODE_MAX: begin
          if (xa > acc_rd) acc_new = xa;
        end
        MODE_ARGMIN: begin
          if (elem_r < best_rd) begin
            best_new = elem_r;
            acc_new  = AW'(row_r);
          end
        end
        MODE_ARGMAX: begin
          if (elem_r > best_rd) begin
            best_new = elem_r;
            acc_new  = AW'(row_r);
          end
        end
        default: acc_new = acc_rd + xa;
      endcase
    end
    mag = acc_new[AW-1] ? AW'(-acc_new) : AW'(acc_new);
  end

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem_r, q_r[DW-1]};
    q_step   = {q_r[DW-2:0], 1'b0};
    rem_step = rem_sh[LW-1:0];
    if (rem_sh >= {1'b0, div_r}) begin
      rem_step  = LW'(rem_sh - {1'b0, div_r});
      q_step[0] = 1'b1;
    end
    q_s      = {1'b0, q_step};
    mean_val = neg_r ? -q_s : q_s;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_push  = 1'b0;
    out_data  = {ctl_r.last_tensor, sat(XW'(acc_new))};
    load      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && !out_full) begin
          q_pop     = 1'b1;
          state_nxt = BK_UPD;
        end
      end
      BK_UPD: begin
        if (ctl_r.emit && mode == MODE_MEAN) begin
          load      = 1'b1;
          state_nxt = BK_DIV;
        end else begin
          out_push  = ctl_r.emit;
          state_nxt = BK_IDLE;
        end
      end
      BK_DIV: begin
        if (cnt_r == CNW'(1)) begin
          out_push  = 1'b1;
          out_data  = {ctl_r.last_tensor, sat(XW'(mean_val))};
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      elem_r <= q_data[EW-1:0];
      col_r  <= q_data[EW +: CIW];
      row_r  <= q_data[EW + CIW +: LW];
      ctl_r  <= ctl_t'(q_data[IW-1 -: CTW]);
    end
    if (load) begin
      neg_r <= acc_new[AW-1];
      q_r   <= {mag, 8'b0};
      rem_r <= '0;
      div_r <= axis;
      cnt_r <= CNW'(DW);
    end else if (state_r == BK_DIV) begin
      q_r   <= q_step;
      rem_r <= rem_step;
      cnt_r <= cnt_r - CNW'(1);
    end
  end

endmodule

// File: rtl/axis_reduction_engine.sv
// axis_reduction_engine: reduces a streamed tensor along its middle axis.
// Words are processed one at a time (RAM read, then update/write of the column),
// and a new word is taken only while the result queue is not full; in mean mode a
// last-row word also runs the bit-serial divide by the axis length first.
// Reset (sync, active low): registers to mode 0, lengths 1, positions zero, queues empty.
module axis_reduction_engine #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_AXIS    = 4096,
  parameter int ELEM_WIDTH  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  are_pkg::cfg_idx_t                 cfg_index,
  input  logic [are_pkg::CFG_DW-1:0]        cfg_data,
  // element words in
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [ELEM_WIDTH-1:0]      in_element,
  // result words out
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [are_pkg::RES_W-1:0]  out_result,
  output logic                              out_last_of_tensor
);
  import are_pkg::*;

  localparam int LW  = $clog2(MAX_AXIS + 1);
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int IW  = $bits(ctl_t) + LW + CIW + ELEM_WIDTH;

  // front -> work queue
  logic          fq_push, fq_full, fq_pop, fq_empty;
  logic [IW-1:0] fq_wdata, fq_rdata;

  // back -> result queue
  logic          rq_push, rq_full;
  logic [RES_W:0] rq_wdata, rq_rdata;

  mode_t         mode;
  logic [LW-1:0] axis;

  // Front: config registers, position counters, row/column classification.
  are_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_AXIS    (MAX_AXIS),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_element (in_element),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_data     (fq_wdata),
    .mode       (mode),
    .axis       (axis)
  );

  assign in_full = fq_full;

  // Two-word queue decoupling the front from the RAM update loop.
  are_fifo #(.WIDTH(IW), .DEPTH(2)) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // Back: accumulator RAMs, update, mean divide, saturation.
  are_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_AXIS    (MAX_AXIS),
    .ELEM_WIDTH  (ELEM_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (fq_empty),
    .q_data   (fq_rdata),
    .q_pop    (fq_pop),
    .mode     (mode),
    .axis     (axis),
    .out_full (rq_full),
    .out_push (rq_push),
    .out_data (rq_wdata)
  );

  // Result queue: lets the back end finish a word while the consumer stalls.
  are_fifo #(.WIDTH(RES_W + 1), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_result         = rq_rdata[RES_W-1:0];
  assign out_last_of_tensor = rq_rdata[RES_W];

endmodule
